FILE: hdl/mvft_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the arctangent table for the map-to-vehicle transform
package mvft_pkg;

  localparam int CFG_IDX_W = 2;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_HEADING  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 2'd2;

  localparam int CORDIC_ITERS = 30;
  localparam int ITER_W       = $clog2(CORDIC_ITERS);

  // angle constants in Q.30, held at 35 bits signed
  localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;
  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [33:0] CORDIC_K    = 34'sd652032874;
  localparam logic signed [31:0] Q30_ONE     = 32'sh40000000;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_PREP,
    CS_ITER,
    CS_DONE
  } cordic_state_t;

  typedef struct packed {
    logic signed [31:0] cosine;
    logic signed [31:0] sine;
  } trig_t;

  // atan(2^-i) in Q2.30
  function automatic logic [31:0] atan_entry(input logic [ITER_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'd843314857;
      5'd1:    v = 32'd497837829;
      5'd2:    v = 32'd263043837;
      5'd3:    v = 32'd133525159;
      5'd4:    v = 32'd67021687;
      5'd5:    v = 32'd33543516;
      5'd6:    v = 32'd16775851;
      5'd7:    v = 32'd8388437;
      5'd8:    v = 32'd4194283;
      5'd9:    v = 32'd2097149;
      default: v = 32'd1 << (5'd30 - i);
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/mvft_cordic.sv
`timescale 1ns / 1ps
// iterative rotation-mode cordic that caches cosine and sine of the heading
module mvft_cordic (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [31:0]  heading,
  output logic                busy,
  output mvft_pkg::trig_t     trig
);
  import mvft_pkg::*;

  cordic_state_t        state_r, state_nxt;
  logic [ITER_W-1:0]    cnt_r;
  logic signed [31:0]   heading_r;
  logic signed [33:0]   x_r, y_r, z_r;
  logic                 flip_r;
  trig_t                trig_r;

  logic signed [34:0]   a_full, a_wrap, a_fold;
  logic                 fold;
  logic signed [33:0]   xs, ys, atan_v, x_fin, y_fin;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -34'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // range reduction to [-pi/2, pi/2], one wrap is always enough
  always_comb begin
    a_full = {heading_r[31], heading_r, 2'b00};
    if (a_full > PI_Q30) begin
      a_wrap = a_full - TWO_PI_Q30;
    end else if (a_full < -PI_Q30) begin
      a_wrap = a_full + TWO_PI_Q30;
    end else begin
      a_wrap = a_full;
    end
    fold = 1'b0;
    if (a_wrap > HALF_PI_Q30) begin
      a_fold = a_wrap - PI_Q30;
      fold   = 1'b1;
    end else if (a_wrap < -HALF_PI_Q30) begin
      a_fold = a_wrap + PI_Q30;
      fold   = 1'b1;
    end else begin
      a_fold = a_wrap;
    end
  end

  always_comb begin
    xs     = x_r >>> cnt_r;
    ys     = y_r >>> cnt_r;
    atan_v = signed'({2'b00, atan_entry(cnt_r)});
    x_fin  = flip_r ? -x_r : x_r;
    y_fin  = flip_r ? -y_r : y_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_IDLE: if (start) state_nxt = CS_PREP;
      CS_PREP: state_nxt = CS_ITER;
      CS_ITER: if (cnt_r == ITER_W'(CORDIC_ITERS - 1)) state_nxt = CS_DONE;
      CS_DONE: state_nxt = CS_IDLE;
      default: state_nxt = CS_IDLE;
    endcase
  end

  always_comb begin
    busy = (state_r != CS_IDLE);
    trig = trig_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= CS_IDLE;
      trig_r.cosine <= Q30_ONE;
      trig_r.sine   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == CS_DONE) begin
        trig_r.cosine <= sat32(x_fin);
        trig_r.sine   <= sat32(y_fin);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      CS_IDLE: begin
        if (start) heading_r <= heading;
      end
      CS_PREP: begin
        x_r    <= CORDIC_K;
        y_r    <= '0;
        z_r    <= a_fold[33:0];
        flip_r <= fold;
        cnt_r  <= '0;
      end
      CS_ITER: begin
        if (!z_r[33]) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - atan_v;
        end else begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + atan_v;
        end
        cnt_r <= cnt_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: hdl/map_to_vehicle_frame_transform.sv
`timescale 1ns / 1ps
// top level: map frame to vehicle frame transform of streamed waypoints
//
//  channel  ports                                   handshake
//  input    start, busy, in_map_x, in_map_y         beat when start & !busy
//  result   out_valid, out_car_x, out_car_y         one-cycle strobe, no stall
//  config   cfg_valid, cfg_ready, cfg_index, cfg_data  beat when valid & ready
//
// one waypoint per cycle while not busy; each result passes the registered
// stages subtract, multiply, sum and round, saturate. a heading write runs
// the cordic (setup, 30 iterations, finish); busy and !cfg_ready hold input
// and config beats off meanwhile. reset restores cosine 1.0 and sine 0.
// the result side cannot stall, so results are never held.
module map_to_vehicle_frame_transform (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [31:0]                 in_map_x,
  input  logic signed [31:0]                 in_map_y,
  output logic                               out_valid,
  output logic signed [31:0]                 out_car_x,
  output logic signed [31:0]                 out_car_y,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mvft_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                        cfg_data
);
  import mvft_pkg::*;

  localparam logic signed [65:0] RND_HALF = 66'sd536870912;

  logic               cfg_beat, in_beat, trig_busy;
  trig_t              trig;
  logic signed [31:0] origin_x_r, origin_y_r;

  logic               v1_r, v2_r, v3_r, out_valid_r;
  logic signed [32:0] dx_r, dy_r;
  logic signed [64:0] pxc_r, pys_r, pyc_r, pxs_r;
  logic signed [65:0] sx_r, sy_r;
  logic signed [31:0] car_x_r, car_y_r;
  logic signed [35:0] sx_sh, sy_sh;

  function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -36'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  assign cfg_ready = !trig_busy;
  assign busy      = trig_busy;
  assign cfg_beat  = cfg_valid && cfg_ready;
  assign in_beat   = start && !trig_busy;

  mvft_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cfg_beat && (cfg_index == REG_HEADING)),
    .heading (signed'(cfg_data)),
    .busy    (trig_busy),
    .trig    (trig)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
    end else if (cfg_beat) begin
      case (cfg_index)
        REG_ORIGIN_X: origin_x_r <= signed'(cfg_data);
        REG_ORIGIN_Y: origin_y_r <= signed'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= in_beat;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  assign sx_sh = 36'(sx_r >>> 30);
  assign sy_sh = 36'(sy_r >>> 30);

  always_ff @(posedge clk) begin
    dx_r    <= 33'(in_map_x) - 33'(origin_x_r);
    dy_r    <= 33'(in_map_y) - 33'(origin_y_r);
    pxc_r   <= dx_r * trig.cosine;
    pys_r   <= dy_r * trig.sine;
    pyc_r   <= dy_r * trig.cosine;
    pxs_r   <= dx_r * trig.sine;
    sx_r    <= 66'(pxc_r) + 66'(pys_r) + RND_HALF;
    sy_r    <= 66'(pyc_r) - 66'(pxs_r) + RND_HALF;
    car_x_r <= sat36(sx_sh);
    car_y_r <= sat36(sy_sh);
  end

  assign out_valid = out_valid_r;
  assign out_car_x = car_x_r;
  assign out_car_y = car_y_r;

endmodule

FILE: hdl/mvft_checker.sv
`timescale 1ns / 1ps
// port-level checker for the transform top level, bound in below
module mvft_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           out_valid,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [mvft_pkg::CFG_IDX_W-1:0] cfg_index
);
  import mvft_pkg::*;

  // every input beat gives a result after it passes the v1, v2, v3 and out_valid registers
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("input beat without result");

  // no result without an input beat that passed the v1, v2, v3 and out_valid registers
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 4))
    else $error("result without input beat");

  // heading write keeps the block busy for the whole cordic run
  a_heading_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && cfg_index == REG_HEADING)
      |=> busy ##31 busy ##1 !busy)
    else $error("cordic run length wrong");

  // origin writes never stall the input side
  a_origin_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && cfg_index != REG_HEADING) |=> !busy)
    else $error("origin write stalled input");

endmodule

bind map_to_vehicle_frame_transform mvft_checker u_mvft_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_index (cfg_index)
);
